[design/rbcf_pkg.sv]
// ----------------------------------------------------------------------------
// rbcf_pkg
// Shared types and constants of the rotated bounding cylinder fit block.
// ----------------------------------------------------------------------------
package rbcf_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // coefficients are signed Q1.14 in 16 bits
  localparam int COEF_W   = 16;
  localparam int COEF_MAX = 16384;
  localparam int RND_SHIFT = 14;
  localparam int RND_HALF  = 8192;

  // config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_Z = 3'd5;

  // square root of a 64-bit value, one result bit per step
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int ROOT_CNT_W = 5;
  localparam int REM_W      = ROOT_W + 4;

  // multiply-accumulate jobs of the rotation, in issue order
  typedef enum logic [2:0] {
    MAC_Y1 = 3'd0,
    MAC_Z1 = 3'd1,
    MAC_Z2 = 3'd2,
    MAC_X2 = 3'd3,
    MAC_XR = 3'd4,
    MAC_YR = 3'd5
  } mac_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    logic     mul_second;
    logic     acc_load;
    logic     wb_en;
    mac_sel_t mac;
    logic     sq_x;
    logic     sq_z;
    logic     upd;
    logic     root_init;
    logic     root_step;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage

[design/rbcf_ctrl.sv]
// ----------------------------------------------------------------------------
// rbcf_ctrl
// Sequencer: walks one vertex through rotation, squaring, extent update and,
// on the last vertex, the square root and the result transfer.
// ----------------------------------------------------------------------------
module rbcf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  rbcf_pkg::dp_sts_t   sts,
  output rbcf_pkg::ctl_cmd_t  cmd
);
  import rbcf_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_ROT  = 8'b00000010,
    ST_SQX  = 8'b00000100,
    ST_SQZ  = 8'b00001000,
    ST_UPD  = 8'b00010000,
    ST_SEED = 8'b00100000,
    ST_ROOT = 8'b01000000,
    ST_EMIT = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {
    PH_A  = 2'd0,
    PH_B  = 2'd1,
    PH_WB = 2'd2
  } phase_t;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  mac_sel_t              mac_r, mac_nxt;
  logic [ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  emit_go;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign emit_go    = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mac_nxt   = mac_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mac   = mac_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          phase_nxt   = PH_A;
          mac_nxt     = MAC_Y1;
          state_nxt   = ST_ROT;
        end
      end
      ST_ROT: begin
        unique case (phase_r)
          PH_A: begin
            cmd.mul_en = 1'b1;
            phase_nxt  = PH_B;
          end
          PH_B: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_second = 1'b1;
            cmd.acc_load   = 1'b1;
            phase_nxt      = PH_WB;
          end
          PH_WB: begin
            cmd.wb_en = 1'b1;
            phase_nxt = PH_A;
            if (mac_r == MAC_YR) begin
              state_nxt = ST_SQX;
            end else begin
              mac_nxt = mac_sel_t'(mac_r + 3'd1);
            end
          end
          default: begin
            phase_nxt = PH_A;
          end
        endcase
      end
      ST_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.sq_z  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last ? ST_SEED : ST_IDLE;
      end
      ST_SEED: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = ROOT_CNT_W'(cnt_r + 1'b1);
        if (cnt_r == ROOT_CNT_W'(ROOT_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_A;
      mac_r       <= MAC_Y1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mac_r       <= mac_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/rbcf_datapath.sv]
// ----------------------------------------------------------------------------
// rbcf_datapath
// Coefficient registers, shared rotation multiplier with rounding and
// saturation, squaring unit, y extent and radius tracking, bit-serial square
// root and the result register.
// ----------------------------------------------------------------------------
module rbcf_datapath #(
  parameter int COORD_WIDTH = rbcf_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbcf_pkg::ctl_cmd_t                cmd,
  output rbcf_pkg::dp_sts_t                 sts,
  input  logic                              cfg_wr,
  input  logic [rbcf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rbcf_pkg::COEF_W-1:0]       cfg_wdata,
  input  logic signed [COORD_WIDTH-1:0]     vertex_x,
  input  logic signed [COORD_WIDTH-1:0]     vertex_y,
  input  logic signed [COORD_WIDTH-1:0]     vertex_z,
  input  logic                              last_vertex,
  output logic signed [COORD_WIDTH-1:0]     center_y,
  output logic [COORD_WIDTH-1:0]            height,
  output logic [COORD_WIDTH-1:0]            radius
);
  import rbcf_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + COEF_W;
  localparam int SW = PW + 1;
  localparam int RW = SW - RND_SHIFT;

  // coefficients, clamped at write
  logic signed [COEF_W-1:0] cx_r, sx_r, cy_r, sy_r, cz_r, sz_r;
  logic signed [COEF_W-1:0] wr_clamped;

  logic signed [CW-1:0] vx_r, vy_r, vz_r;
  logic                 last_r;
  logic signed [CW-1:0] y1_r, z1_r, z2_r, x2_r, xr_r, yr_r;

  logic signed [CW-1:0]     op_a, op_b, mul_op;
  logic signed [COEF_W-1:0] co_a, co_b, mul_co;
  logic signed [PW-1:0]     prod_r, acc_r, prod_nxt;
  logic signed [SW-1:0]     sum_w;
  logic [RW-1:0]            rnd;
  logic [RW-CW:0]           rnd_top;
  logic signed [CW-1:0]     wb_val;

  logic signed [CW-1:0] sq_src;
  logic [CW-1:0]        sq_mag;
  logic [SQ_W-1:0]      sq_mag64;
  logic [ROOT_W-1:0]    sq_low;
  logic [SQ_W-1:0]      sq_val;
  logic [SQ_W-1:0]      sqx_r, sqz_r;
  logic [SQ_W:0]        r2_sum;
  logic [SQ_W-1:0]      r2;

  logic signed [CW-1:0] lowest_r, highest_r;
  logic [SQ_W-1:0]      widest_r;
  logic                 awaiting_r;

  logic [SQ_W-1:0]   n_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_t, trial;
  logic [SQ_W-1:0]   root64;

  logic signed [CW:0]   csum;
  logic signed [CW-1:0] center_r;
  logic [CW-1:0]        height_r, radius_r;

  assign sts.last = last_r;

  // ---------------- configuration ----------------
  always_comb begin
    if (cfg_wdata[COEF_W-1] == 1'b0 && cfg_wdata > COEF_W'(COEF_MAX)) begin
      wr_clamped = COEF_W'(COEF_MAX);
    end else if (cfg_wdata[COEF_W-1] == 1'b1 && cfg_wdata < COEF_W'(-COEF_MAX)) begin
      wr_clamped = COEF_W'(-COEF_MAX);
    end else begin
      wr_clamped = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= COEF_W'(COEF_MAX);
      sx_r <= '0;
      cy_r <= COEF_W'(COEF_MAX);
      sy_r <= '0;
      cz_r <= COEF_W'(COEF_MAX);
      sz_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COS_X: cx_r <= wr_clamped;
        REG_SIN_X: sx_r <= wr_clamped;
        REG_COS_Y: cy_r <= wr_clamped;
        REG_SIN_Y: sy_r <= wr_clamped;
        REG_COS_Z: cz_r <= wr_clamped;
        REG_SIN_Z: sz_r <= wr_clamped;
        default: ;
      endcase
    end
  end

  // ---------------- rotation multiply-accumulate ----------------
  always_comb begin
    unique case (cmd.mac)
      MAC_Y1: begin
        op_a = vy_r;  co_a = cx_r;  op_b = vz_r;  co_b = -sx_r;
      end
      MAC_Z1: begin
        op_a = vy_r;  co_a = sx_r;  op_b = vz_r;  co_b = cx_r;
      end
      MAC_Z2: begin
        op_a = z1_r;  co_a = cy_r;  op_b = vx_r;  co_b = -sy_r;
      end
      MAC_X2: begin
        op_a = z1_r;  co_a = sy_r;  op_b = vx_r;  co_b = cy_r;
      end
      MAC_XR: begin
        op_a = x2_r;  co_a = cz_r;  op_b = y1_r;  co_b = -sz_r;
      end
      MAC_YR: begin
        op_a = x2_r;  co_a = sz_r;  op_b = y1_r;  co_b = cz_r;
      end
      default: begin
        op_a = vy_r;  co_a = cx_r;  op_b = vz_r;  co_b = -sx_r;
      end
    endcase
    mul_op   = cmd.mul_second ? op_b : op_a;
    mul_co   = cmd.mul_second ? co_b : co_a;
    prod_nxt = PW'(mul_op) * PW'(mul_co);
  end

  // round half up back to Q16.16, then saturate
  always_comb begin
    sum_w   = SW'(acc_r) + SW'(prod_r) + SW'(RND_HALF);
    rnd     = sum_w[SW-1:RND_SHIFT];
    rnd_top = rnd[RW-1:CW-1];
    if (rnd_top == '0 || rnd_top == '1) begin
      wb_val = rnd[CW-1:0];
    end else if (rnd[RW-1]) begin
      wb_val = {1'b1, {(CW-1){1'b0}}};
    end else begin
      wb_val = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vx_r   <= vertex_x;
      vy_r   <= vertex_y;
      vz_r   <= vertex_z;
      last_r <= last_vertex;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end
    if (cmd.wb_en) begin
      unique case (cmd.mac)
        MAC_Y1: y1_r <= wb_val;
        MAC_Z1: z1_r <= wb_val;
        MAC_Z2: z2_r <= wb_val;
        MAC_X2: x2_r <= wb_val;
        MAC_XR: xr_r <= wb_val;
        MAC_YR: yr_r <= wb_val;
        default: ;
      endcase
    end
  end

  // ---------------- squares ----------------
  always_comb begin
    sq_src   = cmd.sq_x ? xr_r : z2_r;
    sq_mag   = sq_src[CW-1] ? CW'(-sq_src) : sq_src;
    sq_mag64 = SQ_W'(sq_mag);
    sq_low   = sq_mag64[ROOT_W-1:0];
    // a magnitude above 32 bits saturates its square
    if (|sq_mag64[SQ_W-1:ROOT_W]) begin
      sq_val = '1;
    end else begin
      sq_val = SQ_W'(sq_low) * SQ_W'(sq_low);
    end
    r2_sum = (SQ_W+1)'(sqx_r) + (SQ_W+1)'(sqz_r);
    r2     = r2_sum[SQ_W] ? '1 : r2_sum[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      sqx_r <= sq_val;
    end
    if (cmd.sq_z) begin
      sqz_r <= sq_val;
    end
  end

  // ---------------- extent tracking ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      lowest_r   <= '0;
      highest_r  <= '0;
      widest_r   <= '0;
    end else begin
      if (cmd.upd) begin
        awaiting_r <= 1'b0;
        if (awaiting_r) begin
          lowest_r  <= yr_r;
          highest_r <= yr_r;
          widest_r  <= r2;
        end else begin
          if (yr_r < lowest_r) begin
            lowest_r <= yr_r;
          end
          if (yr_r > highest_r) begin
            highest_r <= yr_r;
          end
          if (r2 > widest_r) begin
            widest_r <= r2;
          end
        end
      end
      if (cmd.out_load) begin
        awaiting_r <= 1'b1;
      end
    end
  end

  // ---------------- square root, one bit per step ----------------
  always_comb begin
    rem_t = {rem_r[REM_W-3:0], n_r[SQ_W-1:SQ_W-2]};
    trial = REM_W'({root_r, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      n_r    <= widest_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      n_r <= {n_r[SQ_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= rem_t - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    csum   = (CW+1)'(lowest_r) + (CW+1)'(highest_r);
    root64 = SQ_W'(root_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      center_r <= csum[CW:1];
      height_r <= highest_r - lowest_r;
      radius_r <= root64[CW-1:0];
    end
  end

  assign center_y = center_r;
  assign height   = height_r;
  assign radius   = radius_r;

endmodule

[design/rotated_bounding_cylinder_fit.sv]
// ----------------------------------------------------------------------------
// rotated_bounding_cylinder_fit
// Rotates a vertex stream about X, Y and Z and fits a y-axis cylinder around
// each set: center y, height and radius, one result per set.
//
//   channel  dir  handshake                 contents
//   in_      in   in_tvalid / in_tready     tdata {z, y, x}, tlast last_vertex
//   out_     out  out_tvalid / out_tready   tdata {radius, height, center_y}
//   cfg_     in   cfg_valid / cfg_ready     cfg_index 0..5, cfg_data Q1.14
//
// A vertex passes through six multiply-accumulates on one shared
// multiplier, two squares and one extent update.
// The last vertex of a set adds the bit-serial square root and the
// result load. rst_n is synchronous; registers reset to the
// identity rotation. The result register holds a transfer while the next
// set streams in; a stalled result only blocks the next last vertex.
// ----------------------------------------------------------------------------
module rotated_bounding_cylinder_fit #(
  parameter int COORD_WIDTH = rbcf_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // x, y, z from the lowest bit up, zero padded to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  input  logic                                   in_tlast,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // center_y, height, radius from the lowest bit up, zero padded to bytes
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rbcf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rbcf_pkg::COEF_W-1:0]            cfg_data
);
  import rbcf_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int DATA_W = ((3*CW+7)/8)*8;

  ctl_cmd_t             cmd;
  dp_sts_t              sts;
  logic signed [CW-1:0] center_y;
  logic [CW-1:0]        height;
  logic [CW-1:0]        radius;

  assign cfg_ready = 1'b1;
  assign out_tdata = DATA_W'({radius, height, center_y});

  rbcf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rbcf_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr      (cfg_valid),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .vertex_x    (in_tdata[CW-1:0]),
    .vertex_y    (in_tdata[2*CW-1:CW]),
    .vertex_z    (in_tdata[3*CW-1:2*CW]),
    .last_vertex (in_tlast),
    .center_y    (center_y),
    .height      (height),
    .radius      (radius)
  );

endmodule

[sim/cylinder_fit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_fit_checker
// Watches the vertex, result and register channels of the cylinder fit block.
// Rotates every accepted vertex with its own copy of the coefficients, keeps
// the y extent and widest squared radius of the open set, and on the last
// vertex queues the expected center, height and radius. Each result transfer
// is compared field by field against the oldest queued fit.
// ----------------------------------------------------------------------------
module cylinder_fit_checker (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic [((3*rbcf_pkg::COORD_WIDTH_DEF+7)/8)*8-1:0]       in_tdata,
  input  logic                                                   in_tlast,
  input  logic                                                   in_tvalid,
  input  logic                                                   in_tready,
  input  logic [((3*rbcf_pkg::COORD_WIDTH_DEF+7)/8)*8-1:0]       out_tdata,
  input  logic                                                   out_tvalid,
  input  logic                                                   out_tready,
  input  logic                                                   cfg_valid,
  input  logic                                                   cfg_ready,
  input  logic [rbcf_pkg::CFG_IDX_W-1:0]                         cfg_index,
  input  logic [rbcf_pkg::COEF_W-1:0]                            cfg_data,
  output int                                                     mismatches,
  output int                                                     pending,
  output int                                                     vertex_count,
  output int                                                     fit_count
);
  import rbcf_pkg::*;

  localparam int CW     = COORD_WIDTH_DEF;
  localparam int DATA_W = ((3*CW+7)/8)*8;

  typedef logic signed [63:0] wide_t;

  localparam wide_t COORD_HI = (wide_t'(1) <<< (CW-1)) - 1;
  localparam wide_t COORD_LO = -COORD_HI - 1;

  typedef struct {
    logic [CW-1:0] center_y;
    logic [CW-1:0] height;
    logic [CW-1:0] radius;
  } cylinder_t;

  cylinder_t        expected_fits[$];
  logic [COEF_W-1:0] coef_reg[6];
  wide_t            lowest_y;
  wide_t            highest_y;
  logic [63:0]      widest_sq;
  logic             fresh_set;

  function automatic wide_t coef_value(logic [COEF_W-1:0] r);
    wide_t c;
    c = wide_t'($signed(r));
    if (c > COEF_MAX) c = COEF_MAX;
    if (c < -COEF_MAX) c = -COEF_MAX;
    return c;
  endfunction

  // a*c + b*s in Q1.14, rounded half up back to Q16.16 and clamped
  function automatic wide_t rot_term(wide_t a, wide_t c, wide_t b, wide_t s);
    wide_t acc;
    acc = (a * c + b * s + RND_HALF) >>> RND_SHIFT;
    if (acc > COORD_HI) acc = COORD_HI;
    if (acc < COORD_LO) acc = COORD_LO;
    return acc;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = n;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic predict_vertex(logic [DATA_W-1:0] data, logic last_v);
    wide_t       x, y, z;
    wide_t       cx, sx, cy, sy, cz, sz;
    wide_t       y1, z1, z2, x2, xr, yr;
    wide_t       mid;
    wide_t       span;
    logic [63:0] r2;
    cylinder_t   fit;
    x  = wide_t'($signed(data[CW-1:0]));
    y  = wide_t'($signed(data[2*CW-1:CW]));
    z  = wide_t'($signed(data[3*CW-1:2*CW]));
    cx = coef_value(coef_reg[REG_COS_X]);
    sx = coef_value(coef_reg[REG_SIN_X]);
    cy = coef_value(coef_reg[REG_COS_Y]);
    sy = coef_value(coef_reg[REG_SIN_Y]);
    cz = coef_value(coef_reg[REG_COS_Z]);
    sz = coef_value(coef_reg[REG_SIN_Z]);
    y1 = rot_term(y, cx, z, -sx);
    z1 = rot_term(y, sx, z, cx);
    z2 = rot_term(z1, cy, x, -sy);
    x2 = rot_term(z1, sy, x, cy);
    xr = rot_term(x2, cz, y1, -sz);
    yr = rot_term(x2, sz, y1, cz);
    // both squares are at most 2^62, so the sum cannot wrap
    r2 = 64'(xr * xr) + 64'(z2 * z2);
    if (fresh_set) begin
      lowest_y  = yr;
      highest_y = yr;
      widest_sq = r2;
      fresh_set = 1'b0;
    end else begin
      if (yr < lowest_y) lowest_y = yr;
      if (yr > highest_y) highest_y = yr;
      if (r2 > widest_sq) widest_sq = r2;
    end
    if (last_v) begin
      mid  = (lowest_y + highest_y) >>> 1;
      span = highest_y - lowest_y;
      fit.center_y = mid[CW-1:0];
      fit.height   = span[CW-1:0];
      fit.radius   = CW'(floor_root(widest_sq));
      expected_fits.push_back(fit);
      fresh_set = 1'b1;
    end
  endtask

  function automatic int field_errors(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %h got %h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    cylinder_t want;
    cylinder_t got;
    if (!rst_n) begin
      coef_reg[REG_COS_X] = COEF_W'(COEF_MAX);
      coef_reg[REG_SIN_X] = '0;
      coef_reg[REG_COS_Y] = COEF_W'(COEF_MAX);
      coef_reg[REG_SIN_Y] = '0;
      coef_reg[REG_COS_Z] = COEF_W'(COEF_MAX);
      coef_reg[REG_SIN_Z] = '0;
      lowest_y     = '0;
      highest_y    = '0;
      widest_sq    = '0;
      fresh_set    = 1'b1;
      expected_fits.delete();
      mismatches   = 0;
      vertex_count = 0;
      fit_count    = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_SIN_Z)
        coef_reg[cfg_index] = cfg_data;
      if (out_tvalid && out_tready) begin
        got.center_y = out_tdata[CW-1:0];
        got.height   = out_tdata[2*CW-1:CW];
        got.radius   = out_tdata[3*CW-1:2*CW];
        if (expected_fits.size() == 0) begin
          $display("%0t: result %h with no fit outstanding", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_fits.pop_front();
          mismatches += field_errors("center_y", want.center_y, got.center_y);
          mismatches += field_errors("height", want.height, got.height);
          mismatches += field_errors("radius", want.radius, got.radius);
          fit_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_vertex(in_tdata, in_tlast);
        vertex_count++;
      end
    end
    pending = expected_fits.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the rotated bounding cylinder fit block.
// Streams vertex sets under a series of rotation settings (identity, right
// angles, clamped out-of-range coefficients, random angles and raw values)
// and varies the pacing of both handshakes. Checking lives in the checker.
// ----------------------------------------------------------------------------
module testbench;
  import rbcf_pkg::*;

  localparam int CW     = COORD_WIDTH_DEF;
  localparam int DATA_W = ((3*CW+7)/8)*8;
  localparam int DRAIN_CYCLES = 80;

  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [CW-1:0] C_MAX  = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] C_MIN  = 32'h8000_0000;
  localparam logic [CW-1:0] C_ZERO = 32'h0000_0000;
  localparam logic [CW-1:0] C_NEG1 = 32'hFFFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n;
  logic [DATA_W-1:0] in_tdata;
  logic              in_tlast;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int vertex_count;
  int fit_count;
  int send_idle_pct;
  int recv_idle_pct;
  int rotation_count;

  always #2 clk = ~clk;

  rotated_bounding_cylinder_fit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cylinder_fit_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tdata    (out_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .vertex_count (vertex_count),
    .fit_count    (fit_count)
  );

  // result side back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_vertex(logic [CW-1:0] vx, logic [CW-1:0] vy, logic [CW-1:0] vz,
                             logic last_v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'({vz, vy, vx});
    in_tlast  <= last_v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block must be idle before a register write
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] extreme_coef();
    case ($urandom_range(4))
      0:       return 16'sd16384;
      1:       return -16'sd16384;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic load_rotation(int kind);
    logic [COEF_W-1:0] c[6];
    real ang;
    case (kind)
      0: begin
        for (int a = 0; a < 3; a++) begin
          ang = $urandom_range(62831) / 10000.0;
          c[2*a]   = COEF_W'($rtoi($cos(ang) * 16384.0));
          c[2*a+1] = COEF_W'($rtoi($sin(ang) * 16384.0));
        end
      end
      1: begin
        for (int k = 0; k < 6; k++) c[k] = COEF_W'($urandom_range(32768) - 16384);
      end
      2: begin
        for (int k = 0; k < 6; k++) c[k] = COEF_W'($urandom);
      end
      default: begin
        for (int k = 0; k < 6; k++) c[k] = extreme_coef();
      end
    endcase
    write_reg(REG_COS_X, c[0]);
    write_reg(REG_SIN_X, c[1]);
    write_reg(REG_COS_Y, c[2]);
    write_reg(REG_SIN_Y, c[3]);
    write_reg(REG_COS_Z, c[4]);
    write_reg(REG_SIN_Z, c[5]);
    if ($urandom_range(2) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, COEF_W'($urandom));
    rotation_count++;
  endtask

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(2097152) - 1048576;
      6: begin
        case ($urandom_range(4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return C_NEG1;
          3:       return 32'h0000_0001;
          default: return C_ZERO;
        endcase
      end
      default:    return $urandom_range(536870912) - 268435456;
    endcase
  endfunction

  task automatic run_sets(int quota);
    int sent;
    int len;
    sent = 0;
    while (sent < quota) begin
      case ($urandom_range(9))
        0:       len = 1;
        1, 2:    len = $urandom_range(9, 20);
        default: len = $urandom_range(2, 8);
      endcase
      for (int v = 0; v < len; v++)
        send_vertex(pick_coord(), pick_coord(), pick_coord(), v == len - 1);
      sent += len;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_COS_X;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    rotation_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity rotation out of reset: extremes and single vertex sets
    send_vertex(C_MAX, C_MIN, C_MAX, 1'b1);
    send_vertex(C_MIN, C_MAX, C_MIN, 1'b1);
    send_vertex(C_ZERO, C_ZERO, C_ZERO, 1'b0);
    send_vertex(C_NEG1, 32'h0000_0001, C_NEG1, 1'b0);
    send_vertex(32'h0000_0001, C_NEG1, 32'h0000_0001, 1'b1);
    drain();

    // clamped coefficients and right angles; first rotated vertex sets the extent
    write_reg(REG_COS_X, 16'h7FFF);
    write_reg(REG_SIN_X, 16'h8000);
    write_reg(REG_COS_Y, 16'h0000);
    write_reg(REG_SIN_Y, 16'sd16384);
    write_reg(REG_COS_Z, -16'sd16384);
    write_reg(REG_SIN_Z, 16'h0000);
    write_reg(REG_SPARE_LO, 16'hA5A5);
    write_reg(REG_SPARE_HI, 16'h5A5A);
    rotation_count++;
    send_vertex(32'h0001_0000, 32'h0002_0000, -32'sh0003_0000, 1'b0);
    send_vertex(C_MAX, C_ZERO, C_ZERO, 1'b0);
    send_vertex(C_ZERO, C_MIN, C_ZERO, 1'b0);
    send_vertex(C_ZERO, C_ZERO, C_MAX, 1'b1);
    send_vertex(32'd5, -32'sd7, 32'd3, 1'b1);
    drain();

    // 45 degrees about every axis, rounding halves and saturation
    for (int k = 0; k < 6; k++) write_reg(k[CFG_IDX_W-1:0], 16'sd11585);
    rotation_count++;
    send_vertex(C_MAX, C_MAX, C_MAX, 1'b0);
    send_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MIN, C_MAX, 1'b0);
    send_vertex(32'h0000_2000, 32'hFFFF_E000, 32'h0000_0001, 1'b0);
    send_vertex(C_NEG1, C_NEG1, C_NEG1, 1'b1);
    send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 1'b0);
    send_vertex(32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 7;  recv_idle_pct = 52; end
        1:       begin send_idle_pct = 52; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        load_rotation(seg);
        run_sets(115);
      end
    end

    drain();
    $display("covered %0d vertices in %0d fitted sets under %0d rotation settings,",
             vertex_count, fit_count, rotation_count);
    $display("with sender and receiver stalls swapped and then removed");
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
